/* hw/rtl/rei_pkg.sv */
// ----------------------------------------------------------------------------
// rei_pkg: shared types and constants of the Rosenbrock integrand block
// Payload structs, fixed-point constants and the quarter-step power table.
// ----------------------------------------------------------------------------
package rei_pkg;

    localparam int NUM_COORDS = 10;
    localparam int MAX_DIMS_DEF = 10;
    localparam int TOTAL_W = 48;

    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [28:0] SUM_CLAMP_Q24 = 29'd268435456;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Reciprocals for exact division of operands below 2^29: x/5 = (x*R5) >> 31,
    // x/3 = (x*R3) >> 30.
    localparam logic [28:0] DIV5_RECIP = 29'd429496730;
    localparam logic [28:0] DIV3_RECIP = 29'd357913942;

    localparam logic [1:0] REG_DIMS = 2'd0;

    typedef struct packed {
        logic       clear_sum;
        logic signed [15:0] coord_9;
        logic signed [15:0] coord_8;
        logic signed [15:0] coord_7;
        logic signed [15:0] coord_6;
        logic signed [15:0] coord_5;
        logic signed [15:0] coord_4;
        logic signed [15:0] coord_3;
        logic signed [15:0] coord_2;
        logic signed [15:0] coord_1;
        logic signed [15:0] coord_0;
    } in_item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] running_total;
        logic [16:0]        integrand_value;
    } out_item_t;

    function automatic logic [30:0] quarter_pow(input logic [1:0] j);
        logic [30:0] v;
        begin
            case (j)
                2'd0: v = 31'd1073741824;
                2'd1: v = 31'd902905651;
                2'd2: v = 31'd759250125;
                2'd3: v = 31'd638450708;
                default: v = 31'd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* hw/rtl/rei_lane.sv */
// ----------------------------------------------------------------------------
// rei_lane: one Rosenbrock term
// Computes (1-a)^2 + 100*((b-a^2)^2 >> 30) in Q.30 over three stages.
// ----------------------------------------------------------------------------
module rei_lane
    import rei_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    output logic [39:0]        term
);

    logic [32:0] t1_reg, t1_next, t1b_reg;
    logic [31:0] ad_reg, ad_next;
    logic [33:0] t2_reg, t2_next;
    logic [39:0] term_reg;
    logic signed [16:0] om;
    logic signed [32:0] d;
    logic [63:0] sq;

    always_comb
    begin
        om = 17'sd32768 - 17'(a);
        t1_next = 33'(34'(om * om));
        d = (33'(b) <<< 15) - 33'(a * a);
        ad_next = d[32] ? 32'(-d) : 32'(d);
        sq = 64'(ad_reg) * 64'(ad_reg);
        t2_next = sq[63:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t1_next;
            ad_reg <= ad_next;
            t1b_reg <= t1_reg;
            t2_reg <= t2_next;
            term_reg <= 40'(t1b_reg) + 40'(t2_reg) * 40'd100;
        end
    end

    assign term = term_reg;

endmodule

/* hw/rtl/rei_merge.sv */
// ----------------------------------------------------------------------------
// rei_merge: term sum and exponential
// Adds the enabled lane terms into a registered sum, then forms exp(-s) in Q1.16.
// ----------------------------------------------------------------------------
module rei_merge
    import rei_pkg::*;
#(
    parameter int LANES = MAX_DIMS_DEF - 1
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [39:0]          terms [LANES],
    input  logic [LANES-1:0]     use_lane,
    output logic [16:0]          value
);

    logic [43:0] s_reg;
    logic [28:0] s24_reg;
    logic [28:0] t_reg;
    logic [29:0] y_reg, y2_reg, y3_reg, y3b_reg, y4_reg, y5_reg;
    logic [29:0] h3_reg;
    logic [30:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [1:0]  j_reg [7];
    logic [4:0]  ip_reg [7];
    logic [16:0] value_reg;
    logic [43:0] s_next;
    logic [59:0] tm;
    logic [51:0] ym;
    logic [58:0] d5, d3;
    logic [61:0] m1, m2, m3, m4;
    logic [60:0] mm;
    logic [30:0] m;
    logic [46:0] rnd;

    always_comb
    begin
        s_next = '0;
        for (int i = 0; i < LANES; i++)
            if (use_lane[i])
                s_next = s_next + 44'(terms[i]);
        tm = 60'(s24_reg) * 60'(LOG2E_Q30);
        ym = 52'(t_reg[21:0]) * 52'(LN2_Q30);
        d5 = 59'(y_reg) * 59'(DIV5_RECIP);
        m1 = 62'(y2_reg) * 62'(p1_reg);
        m2 = 62'(y3_reg) * 62'(p2_reg);
        d3 = 59'(h3_reg) * 59'(DIV3_RECIP);
        m3 = 62'(y4_reg) * 62'(p3_reg);
        m4 = 62'(y5_reg) * 62'(p4_reg);
        mm = 61'(quarter_pow(j_reg[6])) * 61'(p5_reg);
        m = 31'(mm >> 30);
        rnd = (47'(m) + (47'd1 << (13 + ip_reg[6]))) >> (14 + ip_reg[6]);
    end

    // Stages: sum, clamp, log2 scale, y, five Horner steps with the division by
    // three split over two, mantissa.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
            s24_reg <= (s_reg[43:6] > 38'(SUM_CLAMP_Q24)) ? SUM_CLAMP_Q24 : 29'(s_reg[43:6]);
            t_reg <= 29'(tm >> 30);
            y_reg <= 30'(ym >> 24);
            j_reg[0] <= t_reg[23:22];
            ip_reg[0] <= t_reg[28:24];
            p1_reg <= ONE_Q30 - 31'(d5 >> 31);
            y2_reg <= y_reg;
            p2_reg <= ONE_Q30 - 31'((m1 >> 30) / 4);
            y3_reg <= y2_reg;
            h3_reg <= 30'(m2 >> 30);
            y3b_reg <= y3_reg;
            p3_reg <= ONE_Q30 - 31'(d3 >> 30);
            y4_reg <= y3b_reg;
            p4_reg <= ONE_Q30 - 31'((m3 >> 30) / 2);
            y5_reg <= y4_reg;
            p5_reg <= ONE_Q30 - 31'(m4 >> 30);
            for (int k = 1; k < 7; k++)
            begin
                j_reg[k] <= j_reg[k-1];
                ip_reg[k] <= ip_reg[k-1];
            end
            value_reg <= (ip_reg[6] > 5'd16) ? 17'd0 : 17'(rnd);
        end
    end

    assign value = value_reg;

endmodule

/* hw/rtl/rosenbrock_exp_integrand.sv */
// Throughput: one item per cycle while the pipeline advances.
// The depth is set by the lane multipliers, the sum tree and the five Horner steps.
// All stages advance if the output is free or taken or the last stage is empty.
// Reset clears valid bits and the running total, and sets dims_reg to 10.
// ----------------------------------------------------------------------------
// rosenbrock_exp_integrand: exp(-Rosenbrock) evaluator with a running total
// Parallel term lanes feed a merging exponential pipeline and a saturating sum.
// ----------------------------------------------------------------------------
module rosenbrock_exp_integrand
    import rei_pkg::*;
#(
    parameter int MAX_DIMS = MAX_DIMS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    localparam int LAT = 14;
    localparam int LANES = MAX_DIMS - 1;

    logic [3:0] dims_reg;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] clr_reg;
    logic [LANES-1:0] use_reg [3];
    logic en;
    logic signed [15:0] c [NUM_COORDS];
    logic [39:0] terms [LANES];
    logic [16:0] value;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W:0] sum;
    logic [TOTAL_W-1:0] base;
    logic [3:0] n_eff;
    logic [LANES-1:0] use_next;
    out_item_t out_reg;
    logic out_valid_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DIMS) ? {28'd0, dims_reg} : 32'd0;
    assign en = !out_valid_reg || out_ready || !vld_reg[LAT-1];
    assign in_ready = en;

    assign c[0] = in_data.coord_0;
    assign c[1] = in_data.coord_1;
    assign c[2] = in_data.coord_2;
    assign c[3] = in_data.coord_3;
    assign c[4] = in_data.coord_4;
    assign c[5] = in_data.coord_5;
    assign c[6] = in_data.coord_6;
    assign c[7] = in_data.coord_7;
    assign c[8] = in_data.coord_8;
    assign c[9] = in_data.coord_9;

    always_comb
    begin
        n_eff = (dims_reg > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : dims_reg;
        for (int i = 0; i < LANES; i++)
            use_next[i] = (5'(i) + 5'd1) < 5'(n_eff);
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            rei_lane u_lane (
                .clk(clk), .en(en), .a(c[g]), .b(c[g+1]), .term(terms[g])
            );
        end
    endgenerate

    // The lane enables follow the three lane stages so they meet their terms.
    rei_merge #(.LANES(LANES)) u_merge (
        .clk(clk), .en(en), .terms(terms), .use_lane(use_reg[2]), .value(value)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            use_reg[0] <= use_next;
            for (int k = 1; k < 3; k++)
                use_reg[k] <= use_reg[k-1];
        end
    end

    always_comb
    begin
        base = clr_reg[LAT-1] ? '0 : total_reg;
        sum = {1'b0, base} + (TOTAL_W+1)'(value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= 4'd10;
            vld_reg <= '0;
            clr_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == REG_DIMS)
                dims_reg <= pwdata[3:0];
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
                clr_reg <= {clr_reg[LAT-2:0], in_data.clear_sum};
                if (vld_reg[LAT-1])
                    total_reg <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
            if (en && vld_reg[LAT-1])
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[LAT-1])
        begin
            out_reg.integrand_value <= value;
            out_reg.running_total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule
